### sv/fp4wd_pkg.sv
// Shared types, codes and decode functions for the FP4 weight row dot product.
// Used by the float unit, the remainder unit and the top level; depends on nothing.
package fp4wd_pkg;

  localparam int unsigned IDX_W  = 16;
  localparam int unsigned FP_W   = 32;
  localparam int unsigned CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_ROW_LENGTH   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ROW_COUNT    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_GRP_LEN      = 3'd2;
  localparam logic [CFG_IW-1:0] REG_TENSOR_SCALE = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SCALES_EN    = 3'd4;

  localparam logic [FP_W-1:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [FP_W-1:0] FP_NAN  = 32'h7FC0_0000;
  localparam logic [FP_W-1:0] FP_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic            start;
    logic            op_add;
    logic [FP_W-1:0] a;
    logic [FP_W-1:0] b;
  } fpu_req_t;

  function automatic logic [FP_W-1:0] e2m1_decode(input logic [3:0] nib);
    logic [30:0] mag;
    case (nib[2:0])
      3'd0:    mag = 31'h0000_0000;
      3'd1:    mag = 31'h3F00_0000;
      3'd2:    mag = 31'h3F80_0000;
      3'd3:    mag = 31'h3FC0_0000;
      3'd4:    mag = 31'h4000_0000;
      3'd5:    mag = 31'h4040_0000;
      3'd6:    mag = 31'h4080_0000;
      3'd7:    mag = 31'h40C0_0000;
      default: mag = 31'h0000_0000;
    endcase
    return {nib[3], mag};
  endfunction

  function automatic logic [FP_W-1:0] e4m3_decode(input logic [7:0] u);
    logic [7:0]  ex;
    logic [22:0] fr;
    ex = 8'd0;
    fr = 23'd0;
    if (u[6:3] == 4'd0) begin
      case (u[2:0])
        3'd1:    begin ex = 8'd118; fr = 23'h000000; end
        3'd2:    begin ex = 8'd119; fr = 23'h000000; end
        3'd3:    begin ex = 8'd119; fr = 23'h400000; end
        3'd4:    begin ex = 8'd120; fr = 23'h000000; end
        3'd5:    begin ex = 8'd120; fr = 23'h200000; end
        3'd6:    begin ex = 8'd120; fr = 23'h400000; end
        3'd7:    begin ex = 8'd120; fr = 23'h600000; end
        default: begin ex = 8'd0;   fr = 23'h000000; end
      endcase
    end else if (u[6:3] == 4'hF && u[2:0] == 3'd7) begin
      ex = 8'd0;
      fr = 23'd0;
    end else begin
      ex = {4'd0, u[6:3]} + 8'd120;
      fr = {u[2:0], 20'd0};
    end
    return {u[7], ex, fr};
  endfunction

endpackage

### sv/fp4wd_rem.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Reports whether the dividend is a multiple of the divisor; uses fp4wd_pkg.
module fp4wd_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fp4wd_pkg::IDX_W-1:0]   dividend,
  input  logic [fp4wd_pkg::IDX_W-1:0]   divisor,
  output logic                          done,
  output logic                          is_zero
);

  logic                          busy;
  logic [4:0]                    count;
  logic [fp4wd_pkg::IDX_W-1:0]   dvd;
  logic [fp4wd_pkg::IDX_W-1:0]   dsr;
  logic [fp4wd_pkg::IDX_W:0]     rem;
  logic [fp4wd_pkg::IDX_W:0]     trial;

  always_comb begin
    trial = {rem[fp4wd_pkg::IDX_W-1:0], dvd[fp4wd_pkg::IDX_W-1]};
    if (trial >= {1'b0, dsr}) begin
      trial = trial - {1'b0, dsr};
    end
  end

  assign is_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
      dvd   <= '0;
      dsr   <= '0;
      rem   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        dvd   <= dividend;
        dsr   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        rem   <= trial;
        dvd   <= {dvd[fp4wd_pkg::IDX_W-2:0], 1'b0};
        count <= count + 5'd1;
        if (count == 5'(fp4wd_pkg::IDX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/fp4wd_fpu.sv
// Shared float32 multiply/add unit, round to nearest even.
// The first stage forms the raw product or aligned sum; the second normalizes and rounds.
module fp4wd_fpu (
  input  logic                        clk,
  input  logic                        rst,
  input  fp4wd_pkg::fpu_req_t         req,
  output logic                        done,
  output logic [fp4wd_pkg::FP_W-1:0]  result
);

  logic               v1;
  logic               s1_nan;
  logic               s1_inf;
  logic               s1_sign;
  logic signed [11:0] s1_exp;
  logic [47:0]        s1_man;

  logic               c_nan;
  logic               c_inf;
  logic               c_sign;
  logic signed [11:0] c_exp;
  logic [47:0]        c_man;

  function automatic logic [5:0] lzc48(input logic [47:0] m);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) begin
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] pack(input logic sgn, input logic signed [11:0] ex,
                                       input logic [47:0] m);
    logic [5:0]         lz;
    logic [47:0]        mn;
    logic signed [11:0] e;
    logic [11:0]        sh;
    logic [47:0]        mask;
    logic [24:0]        mant;
    logic [7:0]         expf;
    lz   = lzc48(m);
    mn   = m << lz;
    e    = ex - $signed({6'd0, lz});
    sh   = '0;
    mask = '0;
    if (e <= 0) begin
      sh = 12'd1 - e;
      if (sh > 12'd49) begin
        sh = 12'd49;
      end
      mask = ~({48{1'b1}} << sh);
      mn   = (mn >> sh) | {47'd0, |(mn & mask)};
      e    = 12'sd1;
    end
    mant = {1'b0, mn[47:24]};
    if (mn[23] && ((|mn[22:0]) || mn[24])) begin
      mant = mant + 25'd1;
    end
    if (mant[24]) begin
      mant = mant >> 1;
      e    = e + 12'sd1;
    end
    expf = mant[23] ? e[7:0] : 8'd0;
    if (m == '0) begin
      return {sgn, 31'd0};
    end else if (e >= 12'sd255) begin
      return {sgn, 8'hFF, 23'd0};
    end else begin
      return {sgn, expf, mant[22:0]};
    end
  endfunction

  always_comb begin
    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [7:0]  eea, eeb;
    logic        a_big;
    logic [26:0] m_big, m_sml;
    logic [7:0]  e_big, e_sml, d;
    logic [26:0] shifted;
    logic [26:0] lostmask;
    logic [27:0] sum;
    sa = req.a[31];
    sb = req.b[31];
    ea = req.a[30:23];
    eb = req.b[30:23];
    fa = req.a[22:0];
    fb = req.b[22:0];
    a_nan  = (ea == 8'hFF) && (fa != '0);
    b_nan  = (eb == 8'hFF) && (fb != '0);
    a_inf  = (ea == 8'hFF) && (fa == '0);
    b_inf  = (eb == 8'hFF) && (fb == '0);
    a_zero = (ea == 8'h00) && (fa == '0);
    b_zero = (eb == 8'h00) && (fb == '0);
    ma  = {|ea, fa};
    mb  = {|eb, fb};
    eea = (ea == 8'h00) ? 8'd1 : ea;
    eeb = (eb == 8'h00) ? 8'd1 : eb;
    a_big    = (req.a[30:0] >= req.b[30:0]);
    m_big    = a_big ? {ma, 3'b000} : {mb, 3'b000};
    m_sml    = a_big ? {mb, 3'b000} : {ma, 3'b000};
    e_big    = a_big ? eea : eeb;
    e_sml    = a_big ? eeb : eea;
    d        = e_big - e_sml;
    shifted  = '0;
    lostmask = '0;
    sum      = '0;
    if (req.op_add) begin
      c_nan  = a_nan || b_nan || (a_inf && b_inf && (sa != sb));
      c_inf  = a_inf || b_inf;
      c_sign = a_inf ? sa : (b_inf ? sb : (a_big ? sa : sb));
      if (d >= 8'd27) begin
        shifted = {26'd0, |m_sml};
      end else begin
        lostmask = ~({27{1'b1}} << d);
        shifted  = (m_sml >> d) | {26'd0, |(m_sml & lostmask)};
      end
      if (sa == sb) begin
        sum = {1'b0, m_big} + {1'b0, shifted};
      end else begin
        sum = {1'b0, m_big} - {1'b0, shifted};
      end
      if (sum == '0) begin
        c_sign = sa & sb;
      end
      c_exp = $signed({4'd0, e_big}) + 12'sd1;
      c_man = {sum, 20'd0};
    end else begin
      c_nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      c_inf  = a_inf || b_inf;
      c_sign = sa ^ sb;
      c_exp  = $signed({4'd0, eea}) + $signed({4'd0, eeb}) - 12'sd126;
      c_man  = (a_zero || b_zero) ? 48'd0 : (ma * mb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= req.start;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      s1_nan  <= c_nan;
      s1_inf  <= c_inf;
      s1_sign <= c_sign;
      s1_exp  <= c_exp;
      s1_man  <= c_man;
    end
  end

  assign done   = v1;
  assign result = s1_nan ? fp4wd_pkg::FP_NAN :
                  (s1_inf ? {s1_sign, 8'hFF, 23'd0} : pack(s1_sign, s1_exp, s1_man));

endmodule

### sv/fp4_weight_row_dot_product.sv
// Top level of the FP4 weight row dot product: sequencer, state and stream ports.
// Instantiates fp4wd_rem and fp4wd_fpu; uses fp4wd_pkg.
//
// Each request on the s_axis channel carries one matrix element: a float32
// activation, the packed weight byte and the FP8 E4M3 scale byte. After the
// last element of a row, one request on the m_axis channel carries the float32
// row sum (forced to +0 when it is infinite or NaN) and the row number.
// Registers are written on the cfg channel, which is always ready.
// An element passes from its acceptance through the bit-serial remainder unit
// that finds group starts, then four float operations on the single shared
// multiply/add unit, then a bookkeeping state before the next acceptance.
// With per-group scales off the first multiply is skipped.
// s_axis_tready is high only while the block is idle. A finished row sum sits
// in the output register; the block keeps taking elements while it waits and
// stalls only when a second row sum is ready before the first is taken.
// Reset clears the sum, element and row counters and loads the register
// defaults; the block is ready in the cycle after reset is released.
module fp4_weight_row_dot_product #(
  parameter int unsigned DEFAULT_GROUP = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // activation[31:0], weight_byte[39:32], scale_byte[47:40]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // row_sum[31:0], row_number[47:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]  state;
  logic [15:0] row_length;
  logic [15:0] row_count;
  logic [15:0] grp_len;
  logic [31:0] tensor_scale;
  logic        scales_enabled;

  logic [31:0] accumulator;
  logic [15:0] element_index;
  logic [15:0] current_row;
  logic [31:0] group_scale;
  logic [31:0] operand;
  logic [1:0]  step;
  logic [31:0] act;
  logic [7:0]  wbyte;
  logic [7:0]  sbyte;

  logic [31:0] row_sum;
  logic [15:0] row_number;

  logic        accept;
  logic        rem_done;
  logic        rem_zero;
  logic [15:0] gs;
  logic        fpu_done;
  logic [31:0] fpu_result;
  logic [3:0]  nib;
  logic [15:0] index_next;
  logic [16:0] row_inc;
  logic        slot_busy;
  logic        emit_now;
  fp4wd_pkg::fpu_req_t fpu_req;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = {row_number, row_sum};
  assign gs            = (grp_len == '0) ? DEFAULT_GROUP[15:0] : grp_len;
  assign nib           = element_index[0] ? wbyte[7:4] : wbyte[3:0];
  assign index_next    = element_index + 16'd1;
  assign row_inc       = {1'b0, current_row} + 17'd1;
  assign slot_busy     = m_axis_tvalid && !m_axis_tready;
  assign emit_now      = (state == ST_EMIT) && !(index_next < row_length) && !slot_busy;

  always_comb begin
    fpu_req.start  = (state == ST_ISSUE);
    fpu_req.op_add = 1'b0;
    fpu_req.a      = tensor_scale;
    fpu_req.b      = group_scale;
    case (step)
      2'd0: begin
        fpu_req.a = tensor_scale;
        fpu_req.b = group_scale;
      end
      2'd1: begin
        fpu_req.a = fp4wd_pkg::e2m1_decode(nib);
        fpu_req.b = operand;
      end
      2'd2: begin
        fpu_req.a = act;
        fpu_req.b = operand;
      end
      2'd3: begin
        fpu_req.op_add = 1'b1;
        fpu_req.a      = accumulator;
        fpu_req.b      = operand;
      end
      default: begin
        fpu_req.a = tensor_scale;
      end
    endcase
  end

  fp4wd_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (element_index),
    .divisor  (gs),
    .done     (rem_done),
    .is_zero  (rem_zero)
  );

  fp4wd_fpu u_fpu (
    .clk    (clk),
    .rst    (rst),
    .req    (fpu_req),
    .done   (fpu_done),
    .result (fpu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= 16'd16;
      row_count      <= 16'd1;
      grp_len        <= 16'd16;
      tensor_scale   <= fp4wd_pkg::FP_ONE;
      scales_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fp4wd_pkg::REG_ROW_LENGTH:   row_length     <= cfg_data[15:0];
        fp4wd_pkg::REG_ROW_COUNT:    row_count      <= cfg_data[15:0];
        fp4wd_pkg::REG_GRP_LEN:      grp_len        <= cfg_data[15:0];
        fp4wd_pkg::REG_TENSOR_SCALE: tensor_scale   <= cfg_data;
        fp4wd_pkg::REG_SCALES_EN:    scales_enabled <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      accumulator   <= fp4wd_pkg::FP_ZERO;
      element_index <= '0;
      current_row   <= '0;
      group_scale   <= fp4wd_pkg::FP_ZERO;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_now) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (rem_done) begin
            if (rem_zero) begin
              group_scale <= fp4wd_pkg::e4m3_decode(sbyte);
            end
            step  <= scales_enabled ? 2'd0 : 2'd1;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (fpu_done) begin
            if (step == 2'd3) begin
              accumulator <= fpu_result;
              state       <= ST_EMIT;
            end else begin
              step  <= step + 2'd1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_EMIT: begin
          if (index_next < row_length) begin
            element_index <= index_next;
            state         <= ST_IDLE;
          end else if (!slot_busy) begin
            accumulator   <= fp4wd_pkg::FP_ZERO;
            element_index <= '0;
            current_row   <= (row_inc >= {1'b0, row_count}) ? 16'd0 : row_inc[15:0];
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= s_axis_tdata[31:0];
      wbyte <= s_axis_tdata[39:32];
      sbyte <= s_axis_tdata[47:40];
    end
    if (state == ST_MOD && rem_done && !scales_enabled) begin
      operand <= tensor_scale;
    end else if (state == ST_WAIT && fpu_done && step != 2'd3) begin
      operand <= fpu_result;
    end
    if (emit_now) begin
      row_sum    <= (accumulator[30:23] == 8'hFF) ? fp4wd_pkg::FP_ZERO : accumulator;
      row_number <= current_row;
    end
  end

endmodule

### sim/fp4_weight_row_dot_product_test.sv
// Self-checking testbench for the FP4 weight row dot product: drives elements on the input
// stream, predicts each row sum with a float32 model of its own and checks the output stream.
// Depends on fp4wd_pkg and the fp4_weight_row_dot_product RTL.
module fp4_weight_row_dot_product_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GROUP_DEFAULT = 16;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [31:0] row_sum;
    logic [15:0] row_number;
  } row_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  fp4_weight_row_dot_product #(.DEFAULT_GROUP(GROUP_DEFAULT)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the block state.
  logic [15:0] row_length_q;
  logic [15:0] row_count_q;
  logic [15:0] grp_len_q;
  logic [31:0] tensor_scale_q;
  logic        scales_on_q;
  logic [31:0] row_acc;
  logic [15:0] elem_idx;
  logic [15:0] row_idx;
  logic [31:0] latched_scale;

  row_result_t expected_rows[$];
  int          error_count;
  int          hold_count;
  bit          gaps_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("FAILURE");
    $finish;
  end

  function automatic real f32_to_real(input logic [31:0] b);
    if (b[30:23] == 8'hFF)
      return $bitstoreal(b[22:0] != 0 ? 64'h7FF8_0000_0000_0000 : {b[31], 11'h7FF, 52'd0});
    if (b[30:23] == 8'h00) begin
      if (b[22:0] == 0)
        return $bitstoreal({b[31], 63'd0});
      return b[31] ? -(real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000))
                   : real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
  endfunction

  // Rounds a double to float32, nearest-even, with subnormals and overflow to infinity.
  function automatic logic [31:0] real_to_f32(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] v;
    int          ex;
    int          sh;
    d = $realtobits(r);
    ex = int'(d[62:52]);
    if (ex == 2047)
      return d[51:0] != 0 ? fp4wd_pkg::FP_NAN : {d[63], 8'hFF, 23'd0};
    if (ex == 0)
      return {d[63], 31'd0};
    ex = ex - 1023;
    if (ex > 127)
      return {d[63], 8'hFF, 23'd0};
    sig = {11'd1, d[51:0]};
    sh = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh > 60)
      sh = 60;
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0]))
      q = q + 1;
    if (ex >= -126)
      v = (64'(ex + 127) << 23) + q - (64'd1 << 23);
    else
      v = q;
    return {d[63], v[30:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  function automatic logic [31:0] weight_value(input logic [3:0] nib);
    logic [30:0] mag [8];
    mag = '{31'h0, 31'h3F00_0000, 31'h3F80_0000, 31'h3FC0_0000,
            31'h4000_0000, 31'h4040_0000, 31'h4080_0000, 31'h40C0_0000};
    return {nib[3], mag[nib[2:0]]};
  endfunction

  function automatic logic [31:0] scale_value(input logic [7:0] u);
    logic [31:0] v;
    if (u[6:3] == 4'd0) begin
      v = real_to_f32(real'(u[2:0]) * 0.001953125);
      return {u[7], v[30:0]};
    end
    if (u[6:3] == 4'hF && u[2:0] == 3'd7)
      return {u[7], 31'd0};
    return {u[7], 8'(u[6:3] + 8'd120), u[2:0], 20'd0};
  endfunction

  task automatic predict_reset();
    row_length_q = 16'd16;
    row_count_q = 16'd1;
    grp_len_q = 16'd16;
    tensor_scale_q = fp4wd_pkg::FP_ONE;
    scales_on_q = 1'b1;
    row_acc = fp4wd_pkg::FP_ZERO;
    elem_idx = '0;
    row_idx = '0;
    latched_scale = fp4wd_pkg::FP_ZERO;
  endtask

  task automatic predict_register(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      fp4wd_pkg::REG_ROW_LENGTH:   row_length_q = data[15:0];
      fp4wd_pkg::REG_ROW_COUNT:    row_count_q = data[15:0];
      fp4wd_pkg::REG_GRP_LEN:      grp_len_q = data[15:0];
      fp4wd_pkg::REG_TENSOR_SCALE: tensor_scale_q = data;
      fp4wd_pkg::REG_SCALES_EN:    scales_on_q = data[0];
      default: ;
    endcase
  endtask

  task automatic predict_element(input logic [31:0] act, input logic [7:0] wb,
                                 input logic [7:0] sb);
    int unsigned gs;
    logic [31:0] s;
    logic [31:0] p;
    row_result_t res;
    int unsigned next_row;
    gs = (grp_len_q != 0) ? grp_len_q : GROUP_DEFAULT;
    if (int'(elem_idx) % gs == 0)
      latched_scale = scale_value(sb);
    s = tensor_scale_q;
    if (scales_on_q)
      s = f32_mul(s, latched_scale);
    p = f32_mul(weight_value(elem_idx[0] ? wb[7:4] : wb[3:0]), s);
    row_acc = f32_add(row_acc, f32_mul(act, p));
    elem_idx = elem_idx + 16'd1;
    if (elem_idx < row_length_q)
      return;
    res.row_sum = (row_acc[30:23] == 8'hFF) ? fp4wd_pkg::FP_ZERO : row_acc;
    res.row_number = row_idx;
    expected_rows.push_back(res);
    row_acc = fp4wd_pkg::FP_ZERO;
    elem_idx = '0;
    next_row = row_idx + 1;
    row_idx = (next_row >= row_count_q) ? 16'd0 : 16'(next_row);
  endtask

  // Called at a falling edge; returns at a falling edge after the request is taken.
  task automatic send_element(input logic [31:0] act, input logic [7:0] wb,
                              input logic [7:0] sb);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sb, wb, act};
    do @(posedge clk); while (!s_axis_tready);
    predict_element(act, wb, sb);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    predict_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [15:0] len, input logic [15:0] cnt,
                           input logic [15:0] grp, input logic [31:0] gscale, input logic en);
    wait_idle();
    write_register(fp4wd_pkg::REG_ROW_LENGTH, {16'd0, len});
    write_register(fp4wd_pkg::REG_ROW_COUNT, {16'd0, cnt});
    write_register(fp4wd_pkg::REG_GRP_LEN, {16'd0, grp});
    write_register(fp4wd_pkg::REG_TENSOR_SCALE, gscale);
    write_register(fp4wd_pkg::REG_SCALES_EN, {31'd0, en});
  endtask

  function automatic logic [31:0] random_activation();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
      2:       return {1'($urandom), 8'($urandom_range(240, 255)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] random_tensor_scale();
    case ($urandom_range(0, 9))
      0:       return fp4wd_pkg::FP_ONE;
      1:       return fp4wd_pkg::FP_ZERO;
      2:       return 32'h7F80_0000;
      3:       return $urandom();
      4:       return 32'hFF7F_FFFF;
      default: return {1'($urandom), 8'($urandom_range(115, 135)), 23'($urandom)};
    endcase
  endfunction

  task automatic test_weight_codes();
    logic [31:0] acts [16];
    acts = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F7F_FFFF,
             32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'h807F_FFFF,
             32'hFFFF_FFFF, 32'h4049_0FDB, 32'hBF80_0000, 32'h0080_0000,
             32'h3F80_0000, 32'hC2C8_0000, 32'h3E80_0000, 32'h7F80_0000};
    write_all(16'd8, 16'd3, 16'd16, fp4wd_pkg::FP_ONE, 1'b1);
    for (int j = 0; j < 16; j++)
      send_element(acts[j], {4'(j), 4'(j)}, (j == 0) ? 8'h38 : 8'hFF);
  endtask

  task automatic test_scale_codes();
    logic [7:0] codes [10];
    codes = '{8'h00, 8'h01, 8'h07, 8'h08, 8'h7E, 8'h7F, 8'h80, 8'hFF, 8'hF8, 8'h87};
    write_all(16'd2, 16'd5, 16'd1, fp4wd_pkg::FP_ONE, 1'b1);
    for (int j = 0; j < 10; j++)
      send_element(32'h3F80_0000, 8'h22, codes[j]);
  endtask

  task automatic test_register_edges();
    write_all(16'd0, 16'd0, 16'd0, 32'h4000_0000, 1'b0);
    repeat (3) send_element(random_activation(), 8'($urandom), 8'($urandom));
    write_all(16'd65535, 16'd65535, 16'd65535, fp4wd_pkg::FP_ONE, 1'b1);
    repeat (4) send_element(random_activation(), 8'($urandom), 8'($urandom));
    // Shrinking the row below the elements already taken ends it on the next element.
    write_all(16'd2, 16'd65535, 16'd65535, fp4wd_pkg::FP_ONE, 1'b1);
    repeat (3) send_element(random_activation(), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_backpressure();
    write_all(16'd1, 16'd4, 16'd1, fp4wd_pkg::FP_ONE, 1'b1);
    hold_count = 400;
    repeat (30) send_element(random_activation(), 8'($urandom), 8'($urandom));
    wait_idle();
  endtask

  task automatic test_random();
    logic [15:0] len;
    logic [15:0] cnt;
    logic [15:0] grp;
    for (int ph = 0; ph < 40; ph++) begin
      case ($urandom_range(0, 19))
        0, 1:    len = 16'd0;
        2:       len = 16'($urandom_range(100, 200));
        3, 4, 5: len = 16'($urandom_range(9, 40));
        default: len = 16'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0:       cnt = 16'd0;
        1:       cnt = 16'd1;
        2:       cnt = 16'd65535;
        default: cnt = 16'($urandom_range(2, 5));
      endcase
      case ($urandom_range(0, 5))
        0:       grp = 16'd0;
        1:       grp = 16'd1;
        2:       grp = 16'd65535;
        default: grp = 16'($urandom_range(2, 20));
      endcase
      write_all(len, cnt, grp, random_tensor_scale(), 1'($urandom));
      if (ph >= 34)
        gaps_on = 1'b0;
      repeat ($urandom_range(15, 45))
        send_element(random_activation(), 8'($urandom), 8'($urandom));
    end
  endtask

  // Output side: random stalls plus the long hold-off requested by a test.
  initial begin
    int rx_gap;
    rx_gap = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_count > 0) begin
        hold_count--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 17) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    row_result_t exp_row;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_rows.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected row sum %h row %0d", m_axis_tdata[31:0], m_axis_tdata[47:32]);
      end else begin
        exp_row = expected_rows.pop_front();
        if (m_axis_tdata[31:0] !== exp_row.row_sum ||
            m_axis_tdata[47:32] !== exp_row.row_number) begin
          error_count++;
          if (error_count <= 10)
            $display("row mismatch: expected sum %h row %0d, got sum %h row %0d",
                     exp_row.row_sum, exp_row.row_number,
                     m_axis_tdata[31:0], m_axis_tdata[47:32]);
        end
      end
    end
  end

  initial begin
    error_count = 0;
    hold_count = 0;
    gaps_on = 1'b1;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    predict_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_weight_codes();
    test_scale_codes();
    test_register_edges();
    test_backpressure();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### files.f
sv/fp4wd_pkg.sv
sv/fp4wd_rem.sv
sv/fp4wd_fpu.sv
sv/fp4_weight_row_dot_product.sv
sim/fp4_weight_row_dot_product_test.sv
